// ===== hw/rtl/wvt_pkg.sv =====
// Package for the word vocabulary tokenizer: token codes, field widths, queue
// entry type and the vocabulary ROM function.
// Depends on nothing; every other file imports it.
package wvt_pkg;

    localparam int MAX_WORD_LEN_DEF  = 4;
    localparam int VOCAB_ENTRIES_DEF = 18;
    localparam int ROM_SLOTS         = 64;
    localparam int ROM_WIDTH         = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int FIRST_WORD        = 4;

    localparam int TOK_W = 5;
    localparam int PAD_W = 9;
    localparam int CNT_W = 10;

    localparam logic [TOK_W-1:0] TOK_UNK   = 5'd1;
    localparam logic [TOK_W-1:0] TOK_START = 5'd2;
    localparam logic [TOK_W-1:0] TOK_END   = 5'd3;

    localparam logic [CNT_W-1:0] COUNT_MAX     = 10'd1023;
    localparam logic [PAD_W-1:0] PAD_MAX       = 9'd511;
    localparam logic [CNT_W-1:0] PAD_LEN_RESET = 10'd512;

    localparam logic MODE_TEXT = 1'b0;
    localparam logic MODE_END  = 1'b1;

    typedef struct packed {
        logic [4:0]                len;
        logic [ROM_WIDTH-1:0][7:0] text;
    } t_rom_entry;

    // One queue entry holds every result that a single input item causes.
    typedef struct packed {
        logic             start;
        logic             word;
        logic [TOK_W-1:0] word_id;
        logic             fin;
        logic [PAD_W-1:0] pad;
    } t_bundle;

    function automatic t_rom_entry vocab_rom(input logic [5:0] idx);
        t_rom_entry e;
        e = '0;
        unique case (idx)
            6'd4: begin
                e.len = 5'd3; e.text[0] = "t"; e.text[1] = "h"; e.text[2] = "e";
            end
            6'd5: begin
                e.len = 5'd1; e.text[0] = "a";
            end
            6'd6: begin
                e.len = 5'd2; e.text[0] = "a"; e.text[1] = "n";
            end
            6'd7: begin
                e.len = 5'd3; e.text[0] = "a"; e.text[1] = "n"; e.text[2] = "d";
            end
            6'd8: begin
                e.len = 5'd2; e.text[0] = "o"; e.text[1] = "r";
            end
            6'd9: begin
                e.len = 5'd3; e.text[0] = "b"; e.text[1] = "u"; e.text[2] = "t";
            end
            6'd10: begin
                e.len = 5'd2; e.text[0] = "i"; e.text[1] = "n";
            end
            6'd11: begin
                e.len = 5'd2; e.text[0] = "o"; e.text[1] = "n";
            end
            6'd12: begin
                e.len = 5'd2; e.text[0] = "a"; e.text[1] = "t";
            end
            6'd13: begin
                e.len = 5'd2; e.text[0] = "t"; e.text[1] = "o";
            end
            6'd14: begin
                e.len = 5'd3; e.text[0] = "f"; e.text[1] = "o"; e.text[2] = "r";
            end
            6'd15: begin
                e.len = 5'd2; e.text[0] = "o"; e.text[1] = "f";
            end
            6'd16: begin
                e.len = 5'd4; e.text[0] = "w"; e.text[1] = "i"; e.text[2] = "t";
                e.text[3] = "h";
            end
            6'd17: begin
                e.len = 5'd2; e.text[0] = "b"; e.text[1] = "y";
            end
            default: begin
                e = '0;
            end
        endcase
        return e;
    endfunction

endpackage

// ===== hw/rtl/wvt_ifs.sv =====
// Channel interfaces of the word vocabulary tokenizer: text input, token
// output and configuration write. Depends on wvt_pkg.
interface wvt_in_if import wvt_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] text_byte;

    modport source (output valid, output mode, output text_byte, input ready);
    modport sink (input valid, input mode, input text_byte, output ready);
endinterface

interface wvt_out_if import wvt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TOK_W-1:0] token_id;
    logic [PAD_W-1:0] pad_count;
    logic             last_token;

    modport source (output valid, output token_id, output pad_count, output last_token,
                    input ready);
    modport sink (input valid, input token_id, input pad_count, input last_token,
                  output ready);
endinterface

interface wvt_cfg_if import wvt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] padded_length;

    modport source (output valid, output padded_length, input ready);
    modport sink (input valid, input padded_length, output ready);
endinterface

// ===== hw/rtl/wvt_front.sv =====
// Front end: accepts text items, builds words, looks them up in the vocabulary
// ROM and pushes a bundle per item that yields tokens. Depends on wvt_pkg and wvt_ifs.
module wvt_front import wvt_pkg::*; #(
    parameter int MAX_WORD_LEN  = MAX_WORD_LEN_DEF,
    parameter int VOCAB_ENTRIES = VOCAB_ENTRIES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    wvt_in_if.sink   i_in,
    wvt_cfg_if.sink  i_cfg,
    output logic     o_push_vld,
    output t_bundle  o_push_data,
    input  logic     i_push_rdy
);

    localparam int IDXW = $clog2(MAX_WORD_LEN);
    localparam int LENW = $clog2(MAX_WORD_LEN + 1);

    logic [7:0]       r_buf [MAX_WORD_LEN];
    logic [LENW-1:0]  r_len, n_len;
    logic             r_long, n_long;
    logic             r_started, n_started;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_pad_len;

    logic             accept;
    logic             is_end;
    logic             alpha_up;
    logic             alnum;
    logic [7:0]       lc;
    logic             emit_start;
    logic             emit_word;
    logic             buf_wr;
    logic [TOK_W-1:0] word_hit;
    logic [11:0]      cnt_sum;
    logic [11:0]      total_sum;
    logic [CNT_W-1:0] cnt_mid;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] pad_diff;
    logic [PAD_W-1:0] pad;

    assign i_in.ready  = i_push_rdy;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_push_rdy;

    assign is_end   = (i_in.mode == MODE_END);
    assign alpha_up = (i_in.text_byte >= "A") && (i_in.text_byte <= "Z");
    assign alnum    = alpha_up || ((i_in.text_byte >= "a") && (i_in.text_byte <= "z"))
                      || ((i_in.text_byte >= "0") && (i_in.text_byte <= "9"));
    assign lc       = alpha_up ? (i_in.text_byte + 8'h20) : i_in.text_byte;

    assign emit_start = !r_started;
    assign emit_word  = (r_len != '0) && (is_end || !alnum);
    assign buf_wr     = accept && !is_end && alnum && (r_len < LENW'(MAX_WORD_LEN));

    // The lowest matching index wins, so the scan runs from the top down.
    always_comb begin
        t_rom_entry e;
        logic       same;
        word_hit = TOK_UNK;
        for (int i = VOCAB_ENTRIES - 1; i >= FIRST_WORD; i--) begin
            e    = vocab_rom(6'(i));
            same = (e.len == 5'(r_len));
            for (int j = 0; j < MAX_WORD_LEN; j++) begin
                if ((j < int'(r_len)) && (e.text[j] != r_buf[j])) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                word_hit = TOK_W'(i);
            end
        end
    end

    assign cnt_sum   = {2'b00, r_cnt} + 12'(emit_start) + 12'(emit_word);
    assign total_sum = cnt_sum + 12'd1;
    assign cnt_mid   = (cnt_sum > 12'(COUNT_MAX)) ? COUNT_MAX : cnt_sum[CNT_W-1:0];
    assign total     = (total_sum > 12'(COUNT_MAX)) ? COUNT_MAX : total_sum[CNT_W-1:0];
    assign pad_diff  = (r_pad_len > total) ? (r_pad_len - total) : '0;
    assign pad       = (pad_diff > CNT_W'(PAD_MAX)) ? PAD_MAX : pad_diff[PAD_W-1:0];

    assign o_push_vld          = accept && (emit_start || emit_word || is_end);
    assign o_push_data.start   = emit_start;
    assign o_push_data.word    = emit_word;
    assign o_push_data.word_id = r_long ? TOK_UNK : word_hit;
    assign o_push_data.fin     = is_end;
    assign o_push_data.pad     = is_end ? pad : '0;

    always_comb begin
        n_len     = r_len;
        n_long    = r_long;
        n_started = r_started;
        n_cnt     = r_cnt;
        if (accept) begin
            if (is_end) begin
                n_len     = '0;
                n_long    = 1'b0;
                n_started = 1'b0;
                n_cnt     = '0;
            end else begin
                n_started = 1'b1;
                n_cnt     = cnt_mid;
                if (alnum) begin
                    if (r_len < LENW'(MAX_WORD_LEN)) begin
                        n_len = r_len + 1'b1;
                    end else begin
                        n_long = 1'b1;
                    end
                end else if (r_len != '0) begin
                    n_len  = '0;
                    n_long = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_long    <= 1'b0;
            r_started <= 1'b0;
            r_cnt     <= '0;
            r_pad_len <= PAD_LEN_RESET;
        end else begin
            r_len     <= n_len;
            r_long    <= n_long;
            r_started <= n_started;
            r_cnt     <= n_cnt;
            if (i_cfg.valid) begin
                r_pad_len <= i_cfg.padded_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_wr) begin
            r_buf[r_len[IDXW-1:0]] <= lc;
        end
    end

endmodule

// ===== hw/rtl/wvt_queue.sv =====
// Short queue of result bundles between the front end and the back end.
// Depends on wvt_pkg.
module wvt_queue import wvt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_vld,
    input  t_bundle i_push_data,
    output logic    o_push_rdy,
    output logic    o_pop_vld,
    output t_bundle o_pop_data,
    input  logic    i_pop_rdy
);

    localparam int PTRW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_bundle         r_mem [QUEUE_DEPTH];
    logic [PTRW-1:0] r_wr_ptr;
    logic [PTRW-1:0] r_rd_ptr;
    logic [CNTW-1:0] r_cnt;
    logic            push;
    logic            pop;

    assign o_push_rdy = (r_cnt != CNTW'(QUEUE_DEPTH));
    assign o_pop_vld  = (r_cnt != '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = i_pop_rdy && o_pop_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== hw/rtl/wvt_back.sv =====
// Back end: unpacks each bundle into start, word and end tokens, one per cycle
// when not stalled, through a registered output. Depends on wvt_pkg and wvt_ifs.
module wvt_back import wvt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_pop_vld,
    input  t_bundle   i_pop_data,
    output logic      o_pop_rdy,
    wvt_out_if.source o_out
);

    logic [2:0]       r_pend, n_pend;
    logic [TOK_W-1:0] r_word_id;
    logic [PAD_W-1:0] r_pad;
    logic             r_out_vld;
    logic [TOK_W-1:0] r_tok;
    logic [PAD_W-1:0] r_out_pad;
    logic             r_last;

    logic             out_free;
    logic             emit;
    logic [2:0]       sel;
    logic [2:0]       pend_after;
    logic             load;

    assign out_free = !r_out_vld || o_out.ready;
    assign emit     = out_free && (r_pend != '0);

    // Bit 0 is the start token, bit 1 the word, bit 2 the end token.
    always_comb begin
        priority if (r_pend[0]) begin
            sel = 3'b001;
        end else if (r_pend[1]) begin
            sel = 3'b010;
        end else if (r_pend[2]) begin
            sel = 3'b100;
        end else begin
            sel = 3'b000;
        end
    end

    assign pend_after = emit ? (r_pend & ~sel) : r_pend;
    assign o_pop_rdy  = (pend_after == '0);
    assign load       = o_pop_rdy && i_pop_vld;
    assign n_pend     = load ? {i_pop_data.fin, i_pop_data.word, i_pop_data.start}
                             : pend_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word_id <= i_pop_data.word_id;
            r_pad     <= i_pop_data.pad;
        end
        if (emit) begin
            unique case (sel)
                3'b001: begin
                    r_tok     <= TOK_START;
                    r_out_pad <= '0;
                    r_last    <= 1'b0;
                end
                3'b010: begin
                    r_tok     <= r_word_id;
                    r_out_pad <= '0;
                    r_last    <= 1'b0;
                end
                default: begin
                    r_tok     <= TOK_END;
                    r_out_pad <= r_pad;
                    r_last    <= 1'b1;
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.token_id   = r_tok;
    assign o_out.pad_count  = r_out_pad;
    assign o_out.last_token = r_last;

endmodule

// ===== hw/rtl/word_vocab_tokenizer_top.sv =====
// Top level of the word vocabulary tokenizer: front end, bundle queue and
// back end. Depends on wvt_pkg, wvt_ifs, wvt_front, wvt_queue and wvt_back.
//
//   channel  direction  payload                           accepted when
//   i_in     in         mode, text_byte                   valid && ready
//   o_out    out        token_id, pad_count, last_token   valid && ready
//   i_cfg    in         padded_length                     valid && ready
//
// One input item is taken per cycle while the four-entry bundle queue has room.
// The output gives one token per cycle while o_out.ready allows; the first token
// of an accepted item passes through the bundle queue, the back end's pending
// register and its output register.
// Reset is synchronous and restores padded_length to 512.
// Output stalls fill the queue and then drop i_in.ready; i_cfg is always ready.
module word_vocab_tokenizer_top import wvt_pkg::*; #(
    parameter int MAX_WORD_LEN  = MAX_WORD_LEN_DEF,
    parameter int VOCAB_ENTRIES = VOCAB_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wvt_in_if.sink    i_in,
    wvt_cfg_if.sink   i_cfg,
    wvt_out_if.source o_out
);

    logic    push_vld;
    t_bundle push_data;
    logic    push_rdy;
    logic    pop_vld;
    t_bundle pop_data;
    logic    pop_rdy;

    wvt_front #(
        .MAX_WORD_LEN  (MAX_WORD_LEN),
        .VOCAB_ENTRIES (VOCAB_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .o_push_vld  (push_vld),
        .o_push_data (push_data),
        .i_push_rdy  (push_rdy)
    );

    wvt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (push_vld),
        .i_push_data (push_data),
        .o_push_rdy  (push_rdy),
        .o_pop_vld   (pop_vld),
        .o_pop_data  (pop_data),
        .i_pop_rdy   (pop_rdy)
    );

    wvt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop_vld  (pop_vld),
        .i_pop_data (pop_data),
        .o_pop_rdy  (pop_rdy),
        .o_out      (o_out)
    );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for word_vocab_tokenizer_top: drives text and end items,
// predicts the token stream in a behavioral model and checks every output item.
// Depends on wvt_pkg, the channel interfaces in wvt_ifs and the tokenizer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wvt_pkg::*;

    localparam int WORD_MAX     = MAX_WORD_LEN_DEF;
    localparam int VOCAB_COUNT  = VOCAB_ENTRIES_DEF;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
    } t_text_item;

    typedef struct packed {
        logic [TOK_W-1:0] token;
        logic [PAD_W-1:0] pad;
        logic             last;
    } t_token_rec;

    logic i_clk;
    logic i_rst_n;

    wvt_in_if  text_ch ();
    wvt_out_if token_ch ();
    wvt_cfg_if cfg_ch ();

    word_vocab_tokenizer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_ch),
        .i_cfg   (cfg_ch),
        .o_out   (token_ch)
    );

    t_text_item pending_text[$];
    t_token_rec expected_tokens[$];
    t_text_item next_item;
    t_token_rec want_tok;

    logic [7:0]       word_chars[WORD_MAX];
    int               word_len;
    bit               word_long;
    bit               seq_started;
    logic [CNT_W-1:0] token_count;
    logic [CNT_W-1:0] pad_len_model;

    int  items_queued;
    int  items_taken;
    int  tokens_seen;
    int  error_count;
    int  hold_left;
    bit  hold_done;
    bit  steady;
    int  quiet_cycles;

    always #6 i_clk = ~i_clk;

    function automatic string vocab_text(input int idx);
        case (idx)
            4:  return "the";
            5:  return "a";
            6:  return "an";
            7:  return "and";
            8:  return "or";
            9:  return "but";
            10: return "in";
            11: return "on";
            12: return "at";
            13: return "to";
            14: return "for";
            15: return "of";
            16: return "with";
            17: return "by";
            default: return "";
        endcase
    endfunction

    function automatic logic [TOK_W-1:0] lookup_word();
        string w;
        bit    same;
        if (word_long || word_len == 0) return TOK_UNK;
        for (int i = FIRST_WORD; i < VOCAB_COUNT; i++) begin
            w = vocab_text(i);
            same = (w.len() == word_len);
            for (int j = 0; same && j < word_len; j++) begin
                if (w[j] != word_chars[j]) same = 0;
            end
            if (same) return TOK_W'(i);
        end
        return TOK_UNK;
    endfunction

    task automatic emit_token(input logic [TOK_W-1:0] tok, input logic [PAD_W-1:0] pad,
                              input logic last);
        t_token_rec rec;
        rec.token = tok;
        rec.pad   = pad;
        rec.last  = last;
        expected_tokens.insert(expected_tokens.size(), rec);
        if (token_count < COUNT_MAX) token_count++;
    endtask

    task automatic clear_word();
        for (int j = 0; j < WORD_MAX; j++) word_chars[j] = 8'h00;
        word_len  = 0;
        word_long = 0;
    endtask

    task automatic tokenize_item(input logic mode, input logic [7:0] b);
        logic [7:0] c;
        bit         upper;
        bit         alnum;
        int         total;
        int         pad;
        if (!seq_started) begin
            seq_started = 1;
            emit_token(TOK_START, '0, 1'b0);
        end
        if (mode == MODE_TEXT) begin
            c = b;
            upper = (c >= "A" && c <= "Z");
            alnum = upper || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
            if (upper) c = c + 8'd32;
            if (alnum) begin
                if (word_len < WORD_MAX) begin
                    word_chars[word_len] = c;
                    word_len++;
                end else begin
                    word_long = 1;
                end
            end else if (word_len > 0) begin
                emit_token(lookup_word(), '0, 1'b0);
                clear_word();
            end
        end else begin
            if (word_len > 0) emit_token(lookup_word(), '0, 1'b0);
            total = (token_count < COUNT_MAX) ? int'(token_count) + 1 : int'(COUNT_MAX);
            pad = (int'(pad_len_model) > total) ? int'(pad_len_model) - total : 0;
            if (pad > int'(PAD_MAX)) pad = int'(PAD_MAX);
            emit_token(TOK_END, PAD_W'(pad), 1'b1);
            clear_word();
            seq_started = 0;
            token_count = '0;
        end
    endtask

    // Text driver: predicts each item at the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            text_ch.valid <= 1'b0;
        end else begin
            if (text_ch.valid && text_ch.ready) begin
                tokenize_item(text_ch.mode, text_ch.text_byte);
                items_taken++;
            end
            if (!text_ch.valid || text_ch.ready) begin
                if (pending_text.size() > 0 && (steady || $urandom_range(0, 99) >= 10)) begin
                    next_item = pending_text.pop_front();
                    text_ch.valid     <= 1'b1;
                    text_ch.mode      <= next_item.mode;
                    text_ch.text_byte <= next_item.data;
                end else begin
                    text_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Token monitor and receiver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            token_ch.ready <= 1'b0;
        end else begin
            if (token_ch.valid && token_ch.ready) begin
                tokens_seen++;
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token: token_id %0d, pad_count %0d, last_token %0d",
                           token_ch.token_id, token_ch.pad_count, token_ch.last_token);
                    error_count++;
                end else begin
                    want_tok = expected_tokens.pop_front();
                    if (token_ch.token_id !== want_tok.token) begin
                        $error("token_id mismatch: expected %0d, got %0d",
                               want_tok.token, token_ch.token_id);
                        error_count++;
                    end
                    if (token_ch.pad_count !== want_tok.pad) begin
                        $error("pad_count mismatch: expected %0d, got %0d",
                               want_tok.pad, token_ch.pad_count);
                        error_count++;
                    end
                    if (token_ch.last_token !== want_tok.last) begin
                        $error("last_token mismatch: expected %0d, got %0d",
                               want_tok.last, token_ch.last_token);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                token_ch.ready <= 1'b0;
            end else if (!hold_done && tokens_seen >= 30 && pending_text.size() > 20) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
                token_ch.ready <= 1'b0;
            end else begin
                token_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_item(input logic mode, input logic [7:0] b);
        t_text_item it;
        it.mode = mode;
        it.data = b;
        pending_text.insert(pending_text.size(), it);
        items_queued++;
    endtask

    task automatic push_text(input string s);
        for (int j = 0; j < s.len(); j++) push_item(MODE_TEXT, s[j]);
    endtask

    task automatic push_end();
        push_item(MODE_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_separator();
        string punct;
        punct = ",.;:!?-/@[`{~";
        case ($urandom_range(0, 3))
            0: push_item(MODE_TEXT, " ");
            1: push_item(MODE_TEXT, punct[$urandom_range(0, punct.len() - 1)]);
            2: push_item(MODE_TEXT, 8'($urandom_range(128, 255)));
            default: push_item(MODE_TEXT, 8'($urandom_range(0, 47)));
        endcase
    endtask

    task automatic push_random_text(input int count);
        int         start;
        int         r;
        string      w;
        logic [7:0] c;
        start = items_queued;
        while (items_queued - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                push_item(MODE_TEXT, 8'($urandom_range(0, 255)));
            end else if (r < 15) begin
                push_end();
            end else if (r < 60) begin
                w = vocab_text($urandom_range(FIRST_WORD, VOCAB_COUNT - 1));
                for (int j = 0; j < w.len(); j++) begin
                    c = w[j];
                    if ($urandom_range(0, 1)) c = c - 8'd32;
                    push_item(MODE_TEXT, c);
                end
                push_separator();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, 61);
                    if (r < 26) push_item(MODE_TEXT, 8'("a" + r));
                    else if (r < 52) push_item(MODE_TEXT, 8'("A" + r - 26));
                    else push_item(MODE_TEXT, 8'("0" + r - 52));
                end
                push_separator();
            end
        end
    endtask

    task automatic write_padded_length(input logic [CNT_W-1:0] v);
        @(posedge i_clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.padded_length <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        pad_len_model = v;
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [CNT_W-1:0] plens[6];
        plens = '{10'd2, 10'd1023, 10'd7, 10'd600, 10'd512, 10'd40};
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        text_ch.valid        = 1'b0;
        text_ch.mode         = MODE_TEXT;
        text_ch.text_byte    = 8'h00;
        token_ch.ready       = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.padded_length = '0;
        items_queued  = 0;
        items_taken   = 0;
        tokens_seen   = 0;
        error_count   = 0;
        hold_left     = 0;
        hold_done     = 0;
        steady        = 0;
        quiet_cycles  = 0;
        seq_started   = 0;
        token_count   = '0;
        pad_len_model = PAD_LEN_RESET;
        clear_word();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_end();
        push_text("The With,Abcde");
        push_item(MODE_TEXT, 8'hFF);
        push_text("z9`to{");
        push_item(MODE_TEXT, 8'h80);
        push_end();
        wait_drained();

        for (int k = 0; k < 6; k++) begin
            write_padded_length(plens[k]);
            steady = (k == 4);
            push_random_text(38);
            wait_drained();
            steady = 0;
        end

        // A longer sentence under the largest padded length saturates the pad count.
        write_padded_length(10'd1023);
        repeat (28) push_text("a ");
        push_end();
        wait_drained();

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
